@@ hdl/yfd_pkg.sv @@
// ============================================================================
// yfd_pkg
// Shared codes and stage payload types for the Y86-64 fetch and decode block.
// ============================================================================
`default_nettype none

package yfd_pkg;

    // Status codes.
    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_HALTED = 2'd1;
    localparam logic [1:0] ST_EXCEPT = 2'd2;
    localparam logic [1:0] ST_STALL  = 2'd3;

    // Instruction codes.
    localparam logic [3:0] IC_HALT  = 4'h0;
    localparam logic [3:0] IC_NOP   = 4'h1;
    localparam logic [3:0] IC_RRMOV = 4'h2;
    localparam logic [3:0] IC_IRMOV = 4'h3;
    localparam logic [3:0] IC_RMMOV = 4'h4;
    localparam logic [3:0] IC_MRMOV = 4'h5;
    localparam logic [3:0] IC_OPQ   = 4'h6;
    localparam logic [3:0] IC_JXX   = 4'h7;
    localparam logic [3:0] IC_CALL  = 4'h8;
    localparam logic [3:0] IC_RET   = 4'h9;
    localparam logic [3:0] IC_PUSH  = 4'hA;
    localparam logic [3:0] IC_POP   = 4'hB;

    // Highest function code for condition and ALU groups.
    localparam logic [3:0] FN_MAX_GROUP = 4'd6;

    // The register number that means "no register".
    localparam logic [3:0] REG_NONE = 4'hF;

    // Byte counts.
    localparam logic [3:0] BYTES_MAX = 4'd10;
    localparam logic [3:0] LEN_BASE  = 4'd1;
    localparam logic [3:0] LEN_REGS  = 4'd2;
    localparam logic [3:0] LEN_CONST = 4'd8;

    // Beat widths on the stream ports.
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 216;

    // Result of the first stage: opcode split and checked.
    typedef struct packed {
        logic [63:0] pc;
        logic [1:0]  status;
        logic [3:0]  icode;
        logic [3:0]  ifun;
        logic [71:0] tail;      // instruction bytes 1 to 9
        logic [3:0]  avail;     // readable count, limited to ten
    } t_dec;

    // Result of the second stage: operands read and checked.
    typedef struct packed {
        logic [63:0] pc;
        logic [1:0]  status;
        logic [3:0]  icode;
        logic [3:0]  ifun;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] val_c;
        logic [3:0]  size;
    } t_opr;

    // Finished fetch result.
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  icode;
        logic [3:0]  ifun;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] val_c;
        logic [63:0] val_p;
        logic [63:0] next_pc;
    } t_res;

endpackage

`default_nettype wire

@@ hdl/y86_fetch_decode.sv @@
// ============================================================================
// y86_fetch_decode
// Y86-64 fetch and decode stage with mul, div and mod in the ALU group.
// ============================================================================
// Usage:
// The slave stream carries one instruction fetch per beat: the PC, the incoming
// status, ten instruction bytes and the count of bytes that can be read without
// a fault. The master stream returns one decoded result per beat, with the
// status, icode, ifun, both register numbers, valC, valP and the predicted PC.
// A slave beat whose status says stalled is taken and produces no result.
// The work runs through three register stages: opcode decode, operand read
// and check, then valP and next PC. Each beat passes through the stages in
// order, and its result is valid on the master side once it reaches the
// output register. One beat can enter every cycle while results are taken.
// The output register is the third stage, so it also holds a finished result.
// Each stage has its own valid bit and takes a new beat whenever it is empty
// or its content moves on, so bubbles close up while the receiver stalls.
// When the receiver holds tready low, the full stages wait with their beats
// and s_axis_tready drops only once all three stages hold data.
// A synchronous active-low reset empties all stages; payload is not cleared.
// ============================================================================
`default_nettype none

module y86_fetch_decode import yfd_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // pc[63:0], in_status[65:64], bytes_low[129:66], bytes_high[145:130],
    // bytes_readable[149:146], zero fill [151:150]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_status[1:0], icode[5:2], ifun[9:6], reg_a[13:10], reg_b[17:14],
    // val_c[81:18], val_p[145:82], next_pc[209:146], zero fill [215:210]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic s1_valid;
    logic s1_ready;
    t_dec s1_dec;
    logic s2_valid;
    logic s2_ready;
    t_opr s2_opr;
    t_res res;

    // Stage one: split the opcode byte and check the icode and ifun pair.
    yfd_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_pc             (s_axis_tdata[63:0]),
        .i_status         (s_axis_tdata[65:64]),
        .i_bytes_low      (s_axis_tdata[129:66]),
        .i_bytes_high     (s_axis_tdata[145:130]),
        .i_bytes_readable (s_axis_tdata[149:146]),
        .o_valid          (s1_valid),
        .i_ready          (s1_ready),
        .o_dec            (s1_dec)
    );

    // Stage two: register byte, none-register rules and the constant.
    yfd_operands u_operands (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_dec   (s1_dec),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_opr   (s2_opr)
    );

    // Stage three: the 64-bit valP add and next PC selection.
    yfd_pcgen u_pcgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_opr   (s2_opr),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {6'd0, res.next_pc, res.val_p, res.val_c,
                           res.reg_b, res.reg_a, res.ifun, res.icode, res.status};

endmodule

`default_nettype wire

@@ hdl/yfd_decode.sv @@
// ============================================================================
// yfd_decode
// First stage: limits the readable count, splits and checks icode and ifun.
// ============================================================================
`default_nettype none

module yfd_decode import yfd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_pc,
    input  wire logic [1:0]  i_status,
    input  wire logic [63:0] i_bytes_low,
    input  wire logic [15:0] i_bytes_high,
    input  wire logic [3:0]  i_bytes_readable,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_dec             o_dec
);

    logic r_valid;
    t_dec r_dec;
    t_dec n_dec;
    logic n_valid;

    function automatic logic code_ok(input logic [3:0] ic, input logic [3:0] fn);
        logic ok;
        case (ic)
            IC_RRMOV, IC_OPQ, IC_JXX: ok = (fn <= FN_MAX_GROUP);
            IC_HALT, IC_NOP, IC_IRMOV, IC_RMMOV, IC_MRMOV,
            IC_CALL, IC_RET, IC_PUSH, IC_POP: ok = (fn == 4'd0);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    always_comb begin
        n_dec.pc    = i_pc;
        n_dec.tail  = {i_bytes_high, i_bytes_low[63:8]};
        n_dec.avail = (i_bytes_readable > BYTES_MAX) ? BYTES_MAX : i_bytes_readable;
        n_dec.icode = 4'd0;
        n_dec.ifun  = 4'd0;
        n_dec.status = i_status;
        if (i_bytes_readable == 4'd0) begin
            n_dec.status = ST_EXCEPT;
        end else begin
            n_dec.icode = i_bytes_low[7:4];
            n_dec.ifun  = i_bytes_low[3:0];
            if (!code_ok(i_bytes_low[7:4], i_bytes_low[3:0])) begin
                n_dec.status = ST_EXCEPT;
            end
        end
        // A stalled beat is taken and dropped.
        n_valid = i_valid && (i_status != ST_STALL);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && n_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

`default_nettype wire

@@ hdl/yfd_operands.sv @@
// ============================================================================
// yfd_operands
// Second stage: reads and checks the register byte and the 8-byte constant.
// ============================================================================
`default_nettype none

module yfd_operands import yfd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_dec i_dec,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_opr      o_opr
);

    logic r_valid;
    t_opr r_opr;
    t_opr n_opr;
    logic need_regs;
    logic need_const;
    logic [3:0] ra;
    logic [3:0] rb;

    always_comb begin
        case (i_dec.icode)
            IC_RRMOV, IC_IRMOV, IC_RMMOV, IC_MRMOV,
            IC_OPQ, IC_PUSH, IC_POP: need_regs = 1'b1;
            default: need_regs = 1'b0;
        endcase
        case (i_dec.icode)
            IC_IRMOV, IC_RMMOV, IC_MRMOV, IC_JXX, IC_CALL: need_const = 1'b1;
            default: need_const = 1'b0;
        endcase
        ra = i_dec.tail[7:4];
        rb = i_dec.tail[3:0];

        n_opr.pc     = i_dec.pc;
        n_opr.status = i_dec.status;
        n_opr.icode  = i_dec.icode;
        n_opr.ifun   = i_dec.ifun;
        n_opr.reg_a  = REG_NONE;
        n_opr.reg_b  = REG_NONE;
        n_opr.val_c  = 64'd0;
        n_opr.size   = LEN_BASE;

        if (n_opr.status != ST_EXCEPT && need_regs) begin
            if (i_dec.avail < LEN_REGS) begin
                n_opr.status = ST_EXCEPT;
            end else begin
                n_opr.size  = LEN_REGS;
                n_opr.reg_a = ra;
                n_opr.reg_b = rb;
                if (i_dec.icode == IC_IRMOV) begin
                    if (ra != REG_NONE || rb == REG_NONE) n_opr.status = ST_EXCEPT;
                end else if (i_dec.icode == IC_PUSH || i_dec.icode == IC_POP) begin
                    if (ra == REG_NONE || rb != REG_NONE) n_opr.status = ST_EXCEPT;
                end else begin
                    if (ra == REG_NONE || rb == REG_NONE) n_opr.status = ST_EXCEPT;
                end
            end
        end

        if (n_opr.status != ST_EXCEPT && need_const) begin
            if (i_dec.avail < (n_opr.size + LEN_CONST)) begin
                n_opr.status = ST_EXCEPT;
            end else begin
                // The constant follows the register byte when there is one.
                n_opr.val_c = (n_opr.size == LEN_BASE) ? i_dec.tail[63:0] : i_dec.tail[71:8];
                n_opr.size  = n_opr.size + LEN_CONST;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_opr <= n_opr;
        end
    end

    assign o_valid = r_valid;
    assign o_opr   = r_opr;

endmodule

`default_nettype wire

@@ hdl/yfd_pcgen.sv @@
// ============================================================================
// yfd_pcgen
// Third stage: computes valP and the predicted next PC into the output register.
// ============================================================================
`default_nettype none

module yfd_pcgen import yfd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_opr i_opr,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);

    logic r_valid;
    t_res r_res;
    t_res n_res;

    always_comb begin
        n_res.status = i_opr.status;
        n_res.icode  = i_opr.icode;
        n_res.ifun   = i_opr.ifun;
        n_res.reg_a  = i_opr.reg_a;
        n_res.reg_b  = i_opr.reg_b;
        n_res.val_c  = i_opr.val_c;
        n_res.val_p  = i_opr.pc + {60'd0, i_opr.size};
        if (i_opr.status == ST_EXCEPT || i_opr.icode == IC_HALT) begin
            n_res.next_pc = i_opr.pc;
        end else if (i_opr.icode == IC_JXX || i_opr.icode == IC_CALL) begin
            n_res.next_pc = i_opr.val_c;
        end else begin
            n_res.next_pc = n_res.val_p;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

@@ hdl/yfd_checker.sv @@
// ============================================================================
// yfd_checker
// Port-level checks for the Y86-64 fetch and decode block.
// ============================================================================
`default_nettype none

module yfd_checker import yfd_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [1:0]  st;
    logic [3:0]  ic;
    logic [63:0] vc;
    logic [63:0] vp;
    logic [63:0] np;

    assign st = m_axis_tdata[1:0];
    assign ic = m_axis_tdata[5:2];
    assign vc = m_axis_tdata[81:18];
    assign vp = m_axis_tdata[145:82];
    assign np = m_axis_tdata[209:146];

    // A held result beat keeps its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The stalled status is never produced.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> st != ST_STALL)
        else $error("stalled status on result");

    // A halt that fetched fine predicts its own PC, one byte below valP.
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_EXCEPT && ic == IC_HALT |-> np + 64'd1 == vp)
        else $error("halt next PC mismatch");

    // Jumps and calls that fetched fine predict their target.
    a_branch_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_EXCEPT && (ic == IC_JXX || ic == IC_CALL) |-> np == vc)
        else $error("branch next PC mismatch");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind y86_fetch_decode yfd_checker u_yfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
